// ----- sv/wpbt_pkg.sv -----
// Package for the white pixel bounds tracker.
// Holds shared constants, the configuration register codes and the result record.
// No dependencies.
package wpbt_pkg;

    localparam int MAX_DIM_DEF = 4096;
    localparam int CFG_W       = 13;
    localparam int COUNT_W     = 25;
    localparam int COORD_W     = 12;

    localparam logic [7:0]         WHITE_LEVEL      = 8'd255;
    localparam logic [COUNT_W-1:0] COUNT_MAX        = {COUNT_W{1'b1}};
    localparam logic [CFG_W-1:0]   FRAME_WIDTH_RST  = 13'd640;
    localparam logic [CFG_W-1:0]   FRAME_HEIGHT_RST = 13'd480;

    typedef enum logic [0:0] {
        CFG_FRAME_WIDTH  = 1'b0,
        CFG_FRAME_HEIGHT = 1'b1
    } t_cfg_idx;

    typedef struct packed {
        logic               found;
        logic [COUNT_W-1:0] white_count;
        logic [COORD_W-1:0] top_x;
        logic [COORD_W-1:0] top_y;
        logic [COORD_W-1:0] bottom_x;
        logic [COORD_W-1:0] bottom_y;
        logic [COORD_W-1:0] left_x;
        logic [COORD_W-1:0] left_y;
        logic [COORD_W-1:0] right_x;
        logic [COORD_W-1:0] right_y;
        logic [CFG_W-1:0]   box_width;
        logic [CFG_W-1:0]   box_height;
    } t_result;

endpackage

// ----- sv/wpbt_track.sv -----
// Raster position counters and white pixel extreme point tracking.
// Builds the end of frame result record from the updated state.
// Depends on wpbt_pkg.
module wpbt_track #(
    parameter int P_MAX_DIM = wpbt_pkg::MAX_DIM_DEF,
    parameter int P_LW      = ($clog2(P_MAX_DIM) + 1 > wpbt_pkg::CFG_W) ?
                              $clog2(P_MAX_DIM) + 1 : wpbt_pkg::CFG_W
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_accept,
    input  logic [7:0]          i_pixel,
    input  logic [P_LW-1:0]     i_width,
    input  logic [P_LW-1:0]     i_height,
    output logic                o_frame_end,
    output wpbt_pkg::t_result   o_result
);

    localparam int CW = $clog2(P_MAX_DIM);

    logic [CW-1:0] r_col, r_row, n_col, n_row;
    logic [wpbt_pkg::COUNT_W-1:0] r_count, n_count;
    logic r_any, n_any;
    logic [CW-1:0] r_top_x, r_top_y, r_bot_x, r_bot_y;
    logic [CW-1:0] r_left_x, r_left_y, r_right_x, r_right_y;
    logic [CW-1:0] n_top_x, n_top_y, n_bot_x, n_bot_y;
    logic [CW-1:0] n_left_x, n_left_y, n_right_x, n_right_y;

    logic          white;
    logic          row_end;
    logic [P_LW-1:0] col_inc, row_inc;

    assign white   = (i_pixel == wpbt_pkg::WHITE_LEVEL);
    assign col_inc = P_LW'(r_col) + P_LW'(1);
    assign row_inc = P_LW'(r_row) + P_LW'(1);
    assign row_end = (col_inc >= i_width);
    assign o_frame_end = row_end && (row_inc >= i_height);

    always_comb begin
        n_any     = r_any;
        n_count   = r_count;
        n_top_x   = r_top_x;
        n_top_y   = r_top_y;
        n_bot_x   = r_bot_x;
        n_bot_y   = r_bot_y;
        n_left_x  = r_left_x;
        n_left_y  = r_left_y;
        n_right_x = r_right_x;
        n_right_y = r_right_y;
        if (white) begin
            if (!r_any) begin
                n_any     = 1'b1;
                n_top_x   = r_col;
                n_top_y   = r_row;
                n_bot_x   = r_col;
                n_bot_y   = r_row;
                n_left_x  = r_col;
                n_left_y  = r_row;
                n_right_x = r_col;
                n_right_y = r_row;
            end else begin
                if (r_row > r_bot_y) begin
                    n_bot_x = r_col;
                    n_bot_y = r_row;
                end
                if (r_col < r_left_x) begin
                    n_left_x = r_col;
                    n_left_y = r_row;
                end
                if (r_col > r_right_x) begin
                    n_right_x = r_col;
                    n_right_y = r_row;
                end
            end
            if (r_count != wpbt_pkg::COUNT_MAX) begin
                n_count = r_count + 1'b1;
            end
        end
        if (row_end) begin
            n_col = '0;
            n_row = CW'(row_inc);
        end else begin
            n_col = CW'(col_inc);
            n_row = r_row;
        end
    end

    always_comb begin
        o_result.found       = n_any;
        o_result.white_count = n_count;
        o_result.top_x       = wpbt_pkg::COORD_W'(n_top_x);
        o_result.top_y       = wpbt_pkg::COORD_W'(n_top_y);
        o_result.bottom_x    = wpbt_pkg::COORD_W'(n_bot_x);
        o_result.bottom_y    = wpbt_pkg::COORD_W'(n_bot_y);
        o_result.left_x      = wpbt_pkg::COORD_W'(n_left_x);
        o_result.left_y      = wpbt_pkg::COORD_W'(n_left_y);
        o_result.right_x     = wpbt_pkg::COORD_W'(n_right_x);
        o_result.right_y     = wpbt_pkg::COORD_W'(n_right_y);
        if (n_any) begin
            o_result.box_width  = wpbt_pkg::CFG_W'(P_LW'(n_right_x) - P_LW'(n_left_x)
                                                   + P_LW'(1));
            o_result.box_height = wpbt_pkg::CFG_W'(P_LW'(n_bot_y) - P_LW'(n_top_y)
                                                   + P_LW'(1));
        end else begin
            o_result.box_width  = '0;
            o_result.box_height = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col     <= '0;
            r_row     <= '0;
            r_count   <= '0;
            r_any     <= 1'b0;
            r_top_x   <= '0;
            r_top_y   <= '0;
            r_bot_x   <= '0;
            r_bot_y   <= '0;
            r_left_x  <= '0;
            r_left_y  <= '0;
            r_right_x <= '0;
            r_right_y <= '0;
        end else if (i_accept) begin
            if (o_frame_end) begin
                r_col     <= '0;
                r_row     <= '0;
                r_count   <= '0;
                r_any     <= 1'b0;
                r_top_x   <= '0;
                r_top_y   <= '0;
                r_bot_x   <= '0;
                r_bot_y   <= '0;
                r_left_x  <= '0;
                r_left_y  <= '0;
                r_right_x <= '0;
                r_right_y <= '0;
            end else begin
                r_col     <= n_col;
                r_row     <= n_row;
                r_count   <= n_count;
                r_any     <= n_any;
                r_top_x   <= n_top_x;
                r_top_y   <= n_top_y;
                r_bot_x   <= n_bot_x;
                r_bot_y   <= n_bot_y;
                r_left_x  <= n_left_x;
                r_left_y  <= n_left_y;
                r_right_x <= n_right_x;
                r_right_y <= n_right_y;
            end
        end
    end

endmodule

// ----- sv/white_pixel_bounds_tracker_top.sv -----
// Top level of the white pixel bounds tracker: configuration registers,
// stream handshakes and the result register. Depends on wpbt_pkg and wpbt_track.
// The frame result is registered and valid in the cycle after the last pixel's transaction.
// Throughput: one pixel per cycle while input ready is high, set by the single state update stage.
// Input ready drops only while a frame's last pixel waits behind an untaken result.
// Reset clears the position counters, the tracked points and sets the size to 640x480.
module white_pixel_bounds_tracker_top #(
    parameter int P_MAX_DIM = wpbt_pkg::MAX_DIM_DEF
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [0:0]                          i_cfg_idx,
    input  logic [wpbt_pkg::CFG_W-1:0]          i_cfg_data,
    input  logic                                i_valid,
    output logic                                o_ready,
    input  logic [7:0]                          i_pixel,
    output logic                                o_valid,
    input  logic                                i_ready,
    output logic                                o_found,
    output logic [wpbt_pkg::COUNT_W-1:0]        o_white_count,
    output logic [wpbt_pkg::COORD_W-1:0]        o_top_x,
    output logic [wpbt_pkg::COORD_W-1:0]        o_top_y,
    output logic [wpbt_pkg::COORD_W-1:0]        o_bottom_x,
    output logic [wpbt_pkg::COORD_W-1:0]        o_bottom_y,
    output logic [wpbt_pkg::COORD_W-1:0]        o_left_x,
    output logic [wpbt_pkg::COORD_W-1:0]        o_left_y,
    output logic [wpbt_pkg::COORD_W-1:0]        o_right_x,
    output logic [wpbt_pkg::COORD_W-1:0]        o_right_y,
    output logic [wpbt_pkg::CFG_W-1:0]          o_box_width,
    output logic [wpbt_pkg::CFG_W-1:0]          o_box_height
);

    localparam int CW = $clog2(P_MAX_DIM);
    localparam int LW = (CW + 1 > wpbt_pkg::CFG_W) ? CW + 1 : wpbt_pkg::CFG_W;
    localparam logic [LW-1:0] DIM_MAX = LW'(P_MAX_DIM);

    logic [wpbt_pkg::CFG_W-1:0] r_width_cfg, r_height_cfg;
    logic [LW-1:0]              width_eff, height_eff;
    logic                       r_out_valid;
    wpbt_pkg::t_result          r_result, track_result;
    logic                       frame_end, accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width_cfg  <= wpbt_pkg::FRAME_WIDTH_RST;
            r_height_cfg <= wpbt_pkg::FRAME_HEIGHT_RST;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                wpbt_pkg::CFG_FRAME_WIDTH: begin
                    r_width_cfg <= i_cfg_data;
                end
                wpbt_pkg::CFG_FRAME_HEIGHT: begin
                    r_height_cfg <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        if (r_width_cfg == '0) begin
            width_eff = LW'(1);
        end else if (LW'(r_width_cfg) > DIM_MAX) begin
            width_eff = DIM_MAX;
        end else begin
            width_eff = LW'(r_width_cfg);
        end
        if (r_height_cfg == '0) begin
            height_eff = LW'(1);
        end else if (LW'(r_height_cfg) > DIM_MAX) begin
            height_eff = DIM_MAX;
        end else begin
            height_eff = LW'(r_height_cfg);
        end
    end

    assign o_ready = !(r_out_valid && !i_ready && frame_end);
    assign accept  = i_valid && o_ready;

    wpbt_track #(
        .P_MAX_DIM (P_MAX_DIM),
        .P_LW      (LW)
    ) u_track (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_accept    (accept),
        .i_pixel     (i_pixel),
        .i_width     (width_eff),
        .i_height    (height_eff),
        .o_frame_end (frame_end),
        .o_result    (track_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept && frame_end) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && frame_end) begin
            r_result <= track_result;
        end
    end

    assign o_valid       = r_out_valid;
    assign o_found       = r_result.found;
    assign o_white_count = r_result.white_count;
    assign o_top_x       = r_result.top_x;
    assign o_top_y       = r_result.top_y;
    assign o_bottom_x    = r_result.bottom_x;
    assign o_bottom_y    = r_result.bottom_y;
    assign o_left_x      = r_result.left_x;
    assign o_left_y      = r_result.left_y;
    assign o_right_x     = r_result.right_x;
    assign o_right_y     = r_result.right_y;
    assign o_box_width   = r_result.box_width;
    assign o_box_height  = r_result.box_height;

    a_result_follows_frame_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && frame_end) |=> o_valid)
        else $error("A frame end transaction did not produce a result.");

    a_empty_frame_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_found) |-> (o_white_count == '0 && o_box_width == '0 &&
                                   o_box_height == '0 && o_top_x == '0))
        else $error("A frame without white pixels gave a nonzero result.");

    a_found_has_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_found) |-> (o_white_count != '0))
        else $error("A frame with white pixels reported a zero count.");

    a_reset_clears_valid: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("The result valid was not cleared by reset.");

endmodule

// ----- tb/sv/testbench.sv -----
// Self-checking testbench for white_pixel_bounds_tracker_top: streams frames of pixels
// under changing frame sizes and checks every frame result against a built-in predictor.
// Depends on wpbt_pkg and the white_pixel_bounds_tracker_top RTL.
module testbench;

    localparam int CYCLE_LIMIT   = 300000;
    localparam int DRAIN_LIMIT   = 50000;
    localparam int SETTLE_CYCLES = 4;
    localparam int LONG_STALL    = 300;
    localparam int PHASE_ITEMS   = 270;
    localparam int CLAMP_ITEMS   = 30;
    localparam int PRINT_LIMIT   = 40;

    typedef struct packed {
        logic [wpbt_pkg::COORD_W-1:0] x;
        logic [wpbt_pkg::COORD_W-1:0] y;
    } t_point;

    logic                         i_clk      = 1'b0;
    logic                         i_rst_n    = 1'b0;
    logic                         i_cfg_we   = 1'b0;
    wpbt_pkg::t_cfg_idx           i_cfg_idx  = wpbt_pkg::CFG_FRAME_WIDTH;
    logic [wpbt_pkg::CFG_W-1:0]   i_cfg_data = '0;
    logic                         i_valid    = 1'b0;
    logic [7:0]                   i_pixel    = '0;
    logic                         i_ready    = 1'b0;
    logic                         o_ready;
    logic                         o_valid;
    logic                         o_found;
    logic [wpbt_pkg::COUNT_W-1:0] o_white_count;
    logic [wpbt_pkg::COORD_W-1:0] o_top_x, o_top_y, o_bottom_x, o_bottom_y;
    logic [wpbt_pkg::COORD_W-1:0] o_left_x, o_left_y, o_right_x, o_right_y;
    logic [wpbt_pkg::CFG_W-1:0]   o_box_width, o_box_height;

    logic [7:0]        pixel_queue[$];
    wpbt_pkg::t_result expected_boxes[$];
    int pixels_queued     = 0;
    int pixels_accepted   = 0;
    int send_idle_pct     = 21;
    int recv_idle_pct     = 66;
    int stall_requests    = 0;
    int stalls_granted    = 0;
    int stall_cycles_left = 0;
    int results_seen      = 0;
    int mismatch_count    = 0;

    logic [wpbt_pkg::CFG_W-1:0]   width_reg   = wpbt_pkg::FRAME_WIDTH_RST;
    logic [wpbt_pkg::CFG_W-1:0]   height_reg  = wpbt_pkg::FRAME_HEIGHT_RST;
    logic [wpbt_pkg::COORD_W-1:0] col_pos     = '0;
    logic [wpbt_pkg::COORD_W-1:0] row_pos     = '0;
    logic [wpbt_pkg::COUNT_W-1:0] white_total = '0;
    logic                         seen_white  = 1'b0;
    t_point top_pt = '0, bottom_pt = '0, left_pt = '0, right_pt = '0;

    white_pixel_bounds_tracker_top uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data),
        .i_valid       (i_valid),
        .o_ready       (o_ready),
        .i_pixel       (i_pixel),
        .o_valid       (o_valid),
        .i_ready       (i_ready),
        .o_found       (o_found),
        .o_white_count (o_white_count),
        .o_top_x       (o_top_x),
        .o_top_y       (o_top_y),
        .o_bottom_x    (o_bottom_x),
        .o_bottom_y    (o_bottom_y),
        .o_left_x      (o_left_x),
        .o_left_y      (o_left_y),
        .o_right_x     (o_right_x),
        .o_right_y     (o_right_y),
        .o_box_width   (o_box_width),
        .o_box_height  (o_box_height)
    );

    initial begin
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int active_size(input logic [wpbt_pkg::CFG_W-1:0] value);
        if (value == '0) return 1;
        if (int'(value) > wpbt_pkg::MAX_DIM_DEF) return wpbt_pkg::MAX_DIM_DEF;
        return int'(value);
    endfunction

    task automatic track_pixel(input logic [7:0] px);
        int                w, h;
        logic              row_done, frame_done;
        t_point            here;
        wpbt_pkg::t_result box;
        w = active_size(width_reg);
        h = active_size(height_reg);
        here.x = col_pos;
        here.y = row_pos;
        if (px == wpbt_pkg::WHITE_LEVEL) begin
            if (!seen_white) begin
                top_pt     = here;
                bottom_pt  = here;
                left_pt    = here;
                right_pt   = here;
                seen_white = 1'b1;
            end else begin
                if (here.y > bottom_pt.y) bottom_pt = here;
                if (here.x < left_pt.x) left_pt = here;
                if (here.x > right_pt.x) right_pt = here;
            end
            if (white_total != wpbt_pkg::COUNT_MAX) white_total = white_total + 1'b1;
        end
        // A shrunken size ends the row or frame as soon as a counter reaches or passes it.
        row_done   = int'(col_pos) + 1 >= w;
        frame_done = row_done && (int'(row_pos) + 1 >= h);
        if (!frame_done) begin
            if (row_done) begin
                col_pos = '0;
                row_pos = row_pos + 1'b1;
            end else begin
                col_pos = col_pos + 1'b1;
            end
        end else begin
            box = '0;
            if (seen_white) begin
                box.found       = 1'b1;
                box.white_count = white_total;
                box.top_x       = top_pt.x;
                box.top_y       = top_pt.y;
                box.bottom_x    = bottom_pt.x;
                box.bottom_y    = bottom_pt.y;
                box.left_x      = left_pt.x;
                box.left_y      = left_pt.y;
                box.right_x     = right_pt.x;
                box.right_y     = right_pt.y;
                box.box_width   = {1'b0, right_pt.x} - {1'b0, left_pt.x} + 1'b1;
                box.box_height  = {1'b0, bottom_pt.y} - {1'b0, top_pt.y} + 1'b1;
            end
            expected_boxes.insert(expected_boxes.size(), box);
            col_pos     = '0;
            row_pos     = '0;
            white_total = '0;
            seen_white  = 1'b0;
            top_pt      = '0;
            bottom_pt   = '0;
            left_pt     = '0;
            right_pt    = '0;
        end
    endtask

    task automatic report_mismatch(input string msg);
        mismatch_count++;
        if (mismatch_count <= PRINT_LIMIT) $display("ERROR: %s", msg);
    endtask

    task automatic check_field(input string name, input logic [31:0] got,
                               input logic [31:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("result %0d: %s is %0d, expected %0d",
                                      results_seen, name, got, want));
        end
    endtask

    always @(posedge i_clk) begin : pixel_driver
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                track_pixel(i_pixel);
                pixels_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pixel_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    i_valid <= 1'b1;
                    i_pixel <= pixel_queue.pop_front();
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : result_monitor
        wpbt_pkg::t_result want;
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            if (o_valid && i_ready) begin
                results_seen++;
                if (expected_boxes.size() == 0) begin
                    report_mismatch($sformatf("result %0d arrived with none expected",
                                              results_seen));
                end else begin
                    want = expected_boxes.pop_front();
                    check_field("found", o_found, want.found);
                    check_field("white_count", o_white_count, want.white_count);
                    check_field("top_x", o_top_x, want.top_x);
                    check_field("top_y", o_top_y, want.top_y);
                    check_field("bottom_x", o_bottom_x, want.bottom_x);
                    check_field("bottom_y", o_bottom_y, want.bottom_y);
                    check_field("left_x", o_left_x, want.left_x);
                    check_field("left_y", o_left_y, want.left_y);
                    check_field("right_x", o_right_x, want.right_x);
                    check_field("right_y", o_right_y, want.right_y);
                    check_field("box_width", o_box_width, want.box_width);
                    check_field("box_height", o_box_height, want.box_height);
                end
            end
            if (stall_cycles_left > 0) begin
                stall_cycles_left--;
                i_ready <= 1'b0;
            end else if (stalls_granted != stall_requests) begin
                stalls_granted++;
                stall_cycles_left = LONG_STALL;
                i_ready <= 1'b0;
            end else begin
                i_ready <= ($urandom_range(99) >= recv_idle_pct);
            end
        end
    end

    task automatic push_pixel(input logic [7:0] px);
        pixel_queue.insert(pixel_queue.size(), px);
        pixels_queued++;
    endtask

    function automatic logic [7:0] random_pixel(input int white_pct);
        if ($urandom_range(99) < white_pct) return wpbt_pkg::WHITE_LEVEL;
        return 8'($urandom_range(254));
    endfunction

    task automatic wait_drained();
        int guard;
        guard = 0;
        while ((pixels_accepted != pixels_queued || expected_boxes.size() != 0)
               && guard < DRAIN_LIMIT) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input wpbt_pkg::t_cfg_idx idx,
                                  input logic [wpbt_pkg::CFG_W-1:0] value);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= value;
        if (idx == wpbt_pkg::CFG_FRAME_WIDTH) width_reg = value;
        else height_reg = value;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_frame_size(input logic [wpbt_pkg::CFG_W-1:0] w,
                                  input logic [wpbt_pkg::CFG_W-1:0] h);
        write_register(wpbt_pkg::CFG_FRAME_WIDTH, w);
        write_register(wpbt_pkg::CFG_FRAME_HEIGHT, h);
    endtask

    task automatic random_phase(input int n_items);
        int left, seg, dens;
        left = n_items;
        while (left > 0) begin
            wait_drained();
            if ($urandom_range(1) == 0) begin
                set_frame_size(13'($urandom_range(8)), 13'($urandom_range(6)));
            end
            seg = $urandom_range(40, 4);
            if (seg > left) seg = left;
            case ($urandom_range(3))
                0: dens = 0;
                1: dens = 15;
                2: dens = 60;
                default: dens = 95;
            endcase
            repeat (seg) push_pixel(random_pixel(dens));
            left -= seg;
        end
    endtask

    // Tiny frames with the receiver held off make the block back up into its input.
    task automatic pressure_burst();
        wait_drained();
        set_frame_size(13'd1, 13'd2);
        stall_requests++;
        repeat (40) push_pixel(random_pixel(50));
        wait_drained();
    endtask

    initial begin
        int i;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Start under the reset geometry, then shrink the frame in the middle of a row.
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd254);
        push_pixel(8'd127);
        push_pixel(8'd255);
        wait_drained();
        set_frame_size(13'd3, 13'd2);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd128);
        push_pixel(8'd255);

        // Zero sizes act as one, so every pixel closes a frame.
        wait_drained();
        set_frame_size(13'd0, 13'd0);
        push_pixel(8'd255);
        for (i = 0; i < 8; i++) push_pixel(8'(1 << i) & 8'hFF);
        push_pixel(8'd0);
        push_pixel(8'd254);

        wait_drained();
        set_frame_size(13'd3, 13'd3);
        push_pixel(8'd0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd255);
        push_pixel(8'd0);
        push_pixel(8'd0);
        push_pixel(8'd0);
        push_pixel(8'd255);
        push_pixel(8'd255);

        pressure_burst();
        random_phase(PHASE_ITEMS);

        wait_drained();
        send_idle_pct = 66;
        recv_idle_pct = 21;
        random_phase(PHASE_ITEMS);

        wait_drained();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        pressure_burst();
        random_phase(PHASE_ITEMS);

        // Close any partial frame, run part of a row under an oversized setting, then end it.
        wait_drained();
        set_frame_size(13'd1, 13'd1);
        push_pixel(8'd0);
        wait_drained();
        set_frame_size(13'd8191, 13'd8191);
        for (i = 0; i < CLAMP_ITEMS; i++) begin
            push_pixel((i % 7 == 0) ? wpbt_pkg::WHITE_LEVEL : random_pixel(10));
        end
        wait_drained();
        set_frame_size(13'd1, 13'd1);
        push_pixel(wpbt_pkg::WHITE_LEVEL);

        wait_drained();
        if (expected_boxes.size() != 0) begin
            report_mismatch($sformatf("%0d frame results never arrived",
                                      expected_boxes.size()));
        end
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
